// ----- rtl/pps_pkg.sv -----
// types, codes and table record for the preemptive priority scheduler
`default_nettype none
package pps_pkg;

  localparam int unsigned TABLE_DEPTH_DEF = 16;

  localparam logic       OP_ARRIVE = 1'b0;
  localparam logic       OP_TICK   = 1'b1;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_ZERO   = 2'd2;

  typedef struct packed {
    logic        opcode;
    logic [15:0] task_id;
    logic [7:0]  task_priority;
    logic [15:0] burst_length;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        ran_valid;
    logic [15:0] ran_id;
    logic        order_append;
    logic        completed;
    logic [31:0] finish_time;
    logic [31:0] turnaround;
    logic [31:0] wait_total;
  } result_t;

  // base holds the run-tick count at arrival; wait is derived from it at completion
  typedef struct packed {
    logic [15:0] id;
    logic [7:0]  prio;
    logic [31:0] arrival;
    logic [15:0] remaining;
    logic [15:0] burst;
    logic [31:0] base;
    logic [31:0] stamp;
  } entry_t;

endpackage
`default_nettype wire

// ----- rtl/preemptive_priority_scheduler.sv -----
// preemptive priority scheduler top level: task table memory, scan and dispatch
`default_nettype none
// An arrive transaction is taken while idle and its result is registered, showing
// in the next cycle; busy stays low, so arrivals can follow back to back. A tick
// transaction scans the task table memory one entry per cycle through its single
// read port, then uses the decide state for preemption, dispatch and the run
// update; busy is high through the scan and decide states, and the result strobes
// as the block returns to idle. Every transaction gives exactly one result, shown
// for one cycle on out_valid, and the receiver cannot hold it off.
module preemptive_priority_scheduler #(
  parameter int unsigned TABLE_DEPTH = pps_pkg::TABLE_DEPTH_DEF
) (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              start,
  output logic             busy,
  input  pps_pkg::cmd_t    in_data,
  output logic             out_valid,
  output pps_pkg::result_t out_data
);

  localparam int unsigned SW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 2);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SCAN   = 3'b010,
    S_DECIDE = 3'b100
  } state_t;

  state_t                   state_r, state_nxt;
  pps_pkg::entry_t          mem [TABLE_DEPTH];
  pps_pkg::entry_t          rd_data_r;
  logic [SW-1:0]            rd_slot_r;
  logic                     rd_pend_r;
  logic [CW-1:0]            cnt_r;
  logic [TABLE_DEPTH-1:0]   valid_r, valid_nxt;
  logic [31:0]              time_r, time_nxt;
  logic [31:0]              stamp_r, stamp_nxt;
  logic [31:0]              runs_r, runs_nxt;
  logic                     run_vld_r, run_vld_nxt;
  logic [SW-1:0]            run_slot_r, run_slot_nxt;
  pps_pkg::entry_t          run_r, run_nxt;
  logic [16:0]              last_id_r, last_id_nxt;
  pps_pkg::entry_t          best_r;
  logic [SW-1:0]            best_slot_r;
  logic                     best_vld_r;
  logic                     out_valid_r, out_valid_nxt;
  pps_pkg::result_t         out_r, out_nxt;

  logic                     accept;
  logic                     free_found;
  logic [SW-1:0]            free_slot;
  logic                     issue;
  logic                     issue_queued;
  logic                     take_best;
  logic                     we;
  logic [SW-1:0]            wr_addr;
  pps_pkg::entry_t          wr_data;
  logic                     preempt;
  logic                     disp;
  logic                     active;
  pps_pkg::entry_t          cur;
  logic [SW-1:0]            cur_slot;
  logic [15:0]              rem;
  logic [31:0]              fin;

  assign accept    = start && !busy;
  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // lowest free entry
  always_comb begin
    free_found = 1'b0;
    free_slot  = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (!valid_r[i] && !free_found) begin
        free_found = 1'b1;
        free_slot  = SW'(i);
      end
    end
  end

  assign issue        = (state_r == S_SCAN) && (cnt_r < CW'(TABLE_DEPTH));
  assign issue_queued = valid_r[cnt_r[SW-1:0]] &&
                        !(run_vld_r && run_slot_r == cnt_r[SW-1:0]);
  // strictly better only, so the lower entry keeps a full tie
  assign take_best    = rd_pend_r && (!best_vld_r ||
                        ({rd_data_r.prio, rd_data_r.arrival, rd_data_r.stamp} <
                         {best_r.prio, best_r.arrival, best_r.stamp}));

  assign preempt  = run_vld_r && best_vld_r && (best_r.prio < run_r.prio);
  assign disp     = (!run_vld_r || preempt) && best_vld_r;
  assign active   = disp || run_vld_r;
  assign cur      = disp ? best_r : run_r;
  assign cur_slot = disp ? best_slot_r : run_slot_r;
  assign rem      = cur.remaining - 16'd1;
  assign fin      = time_r + 32'd1;

  always_comb begin
    state_nxt     = state_r;
    valid_nxt     = valid_r;
    time_nxt      = time_r;
    stamp_nxt     = stamp_r;
    runs_nxt      = runs_r;
    run_vld_nxt   = run_vld_r;
    run_slot_nxt  = run_slot_r;
    run_nxt       = run_r;
    last_id_nxt   = last_id_r;
    out_valid_nxt = 1'b0;
    out_nxt       = '0;
    we            = 1'b0;
    wr_addr       = free_slot;
    wr_data       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_data.opcode == pps_pkg::OP_ARRIVE) begin
            out_valid_nxt = 1'b1;
            if (in_data.burst_length == 16'd0) begin
              out_nxt.status = pps_pkg::ST_ZERO;
            end else if (!free_found) begin
              out_nxt.status = pps_pkg::ST_FULL;
            end else begin
              out_nxt.status       = pps_pkg::ST_OK;
              we                   = 1'b1;
              wr_data.id           = in_data.task_id;
              wr_data.prio         = in_data.task_priority;
              wr_data.arrival      = time_r;
              wr_data.remaining    = in_data.burst_length;
              wr_data.burst        = in_data.burst_length;
              wr_data.base         = runs_r;
              wr_data.stamp        = stamp_r;
              valid_nxt[free_slot] = 1'b1;
              stamp_nxt            = stamp_r + 32'd1;
            end
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (cnt_r == CW'(TABLE_DEPTH)) begin
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        state_nxt     = S_IDLE;
        out_valid_nxt = 1'b1;
        time_nxt      = fin;
        if (preempt) begin
          // running task goes back to the queue with a fresh stamp
          we            = 1'b1;
          wr_addr       = run_slot_r;
          wr_data       = run_r;
          wr_data.stamp = stamp_r;
          stamp_nxt     = stamp_r + 32'd1;
        end
        if (active) begin
          runs_nxt            = runs_r + 32'd1;
          out_nxt.ran_valid   = 1'b1;
          out_nxt.ran_id      = cur.id;
          if (disp && last_id_r != {1'b0, cur.id}) begin
            out_nxt.order_append = 1'b1;
            last_id_nxt          = {1'b0, cur.id};
          end
          run_slot_nxt  = cur_slot;
          run_nxt       = cur;
          run_nxt.remaining = rem;
          if (rem == 16'd0) begin
            run_vld_nxt          = 1'b0;
            valid_nxt[cur_slot]  = 1'b0;
            out_nxt.completed    = 1'b1;
            out_nxt.finish_time  = fin;
            out_nxt.turnaround   = fin - cur.arrival;
            out_nxt.wait_total   = runs_nxt - cur.base - {16'd0, cur.burst};
          end else begin
            run_vld_nxt = 1'b1;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // table memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    if (issue) begin
      rd_data_r <= mem[cnt_r[SW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      time_r      <= '0;
      stamp_r     <= '0;
      runs_r      <= '0;
      run_vld_r   <= 1'b0;
      run_slot_r  <= '0;
      last_id_r   <= 17'h10000;
      out_valid_r <= 1'b0;
      rd_pend_r   <= 1'b0;
      best_vld_r  <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      time_r      <= time_nxt;
      stamp_r     <= stamp_nxt;
      runs_r      <= runs_nxt;
      run_vld_r   <= run_vld_nxt;
      run_slot_r  <= run_slot_nxt;
      last_id_r   <= last_id_nxt;
      out_valid_r <= out_valid_nxt;
      rd_pend_r   <= issue && issue_queued;
      if (state_r == S_IDLE) begin
        cnt_r      <= '0;
        best_vld_r <= 1'b0;
      end else if (state_r == S_SCAN) begin
        cnt_r <= cnt_r + CW'(1);
        if (take_best) begin
          best_vld_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    run_r     <= run_nxt;
    out_r     <= out_nxt;
    rd_slot_r <= cnt_r[SW-1:0];
    if (take_best && state_r == S_SCAN) begin
      best_r      <= rd_data_r;
      best_slot_r <= rd_slot_r;
    end
  end

  a_run_valid : assert property (@(posedge clk) disable iff (!rst_n)
    run_vld_r |-> valid_r[run_slot_r])
    else $error("running slot is not a valid entry");

  a_decide_done : assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DECIDE |=> state_r == S_IDLE && out_valid_r)
    else $error("tick did not give its result");

  a_reject_quiet : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.status != pps_pkg::ST_OK |-> !out_r.ran_valid && !out_r.completed)
    else $error("rejected arrival reports a run");

  a_no_strobe_scan : assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SCAN |-> !out_valid_nxt)
    else $error("result strobe during table scan");

endmodule
`default_nettype wire
